FILE: src/tch_pkg.sv
// Shared types, constants and the arctangent table for the tilt-compensated heading block.
`timescale 1ns / 1ps
package tch_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int STEPS        = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

	localparam int SW = 16;   // samples and Q3.13 angles
	localparam int AW = 35;   // Q5.30 angle accumulators
	localparam int RW = 34;   // rotation-mode CORDIC datapath
	localparam int TW = 32;   // sin/cos in Q2.30
	localparam int PW = SW + TW;
	localparam int HW = 52;   // horizontal field components

	typedef logic signed [SW-1:0] smp_t;
	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [RW-1:0] rot_t;
	typedef logic signed [TW-1:0] trig_t;
	typedef logic signed [PW-1:0] prd_t;
	typedef logic signed [HW-1:0] fld_t;

	localparam ang_t PI_Q30      = 35'sd3373259426;
	localparam ang_t HALF_PI_Q30 = 35'sd1686629713;
	localparam rot_t GAIN_Q30    = 34'sd652032874;
	localparam ang_t ROUND_Q30   = 35'sd65536;
	localparam int   HEAD_MAX    = 25736;
	localparam int   ONE_SHIFT   = 30;
	localparam int   OUT_SHIFT   = 17;

	// Sines and cosines of one sample, carried with the raw field readings.
	typedef struct packed {
		trig_t cp;
		trig_t sp;
		trig_t cr;
		trig_t sr;
		smp_t  mx;
		smp_t  my;
		smp_t  mz;
	} tilt_t;

	// atan(2^-i) in Q2.30, truncated
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] r;
		unique case (i)
			0:  r = 32'h3243F6A8;
			1:  r = 32'h1DAC6705;
			2:  r = 32'h0FADBAFC;
			3:  r = 32'h07F56EA6;
			4:  r = 32'h03FEAB76;
			5:  r = 32'h01FFD55B;
			6:  r = 32'h00FFFAAA;
			7:  r = 32'h007FFF55;
			8:  r = 32'h003FFFEA;
			9:  r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/tch_tilt.sv
// Pipelined rotation CORDIC giving sin and cos of pitch and roll, one stage per step.
`timescale 1ns / 1ps
module tch_tilt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  tch_pkg::smp_t mag_x,
	input  tch_pkg::smp_t mag_y,
	input  tch_pkg::smp_t mag_z,
	input  tch_pkg::smp_t pitch_angle,
	input  tch_pkg::smp_t roll_angle,
	output logic          out_valid,
	output tch_pkg::tilt_t tilt
);
	import tch_pkg::*;

	logic  v_s  [0:STEPS];
	rot_t  px_s [0:STEPS];
	rot_t  py_s [0:STEPS];
	ang_t  pz_s [0:STEPS];
	rot_t  rx_s [0:STEPS];
	rot_t  ry_s [0:STEPS];
	ang_t  rz_s [0:STEPS];
	logic  pf_s [0:STEPS];
	logic  rf_s [0:STEPS];
	smp_t  mx_s [0:STEPS];
	smp_t  my_s [0:STEPS];
	smp_t  mz_s [0:STEPS];

	logic  fv_s;
	tilt_t tilt_s;

	ang_t pz_in, rz_in, pz_red, rz_red;
	logic pflip, rflip;

	// Fold angles beyond a quarter turn back by pi; negate sin and cos at the end.
	always_comb begin
		pz_in  = ang_t'(pitch_angle) <<< OUT_SHIFT;
		rz_in  = ang_t'(roll_angle) <<< OUT_SHIFT;
		pz_red = pz_in;
		pflip  = 1'b0;
		rz_red = rz_in;
		rflip  = 1'b0;
		if (pz_in > HALF_PI_Q30) begin
			pz_red = pz_in - PI_Q30;
			pflip  = 1'b1;
		end else if (pz_in < -HALF_PI_Q30) begin
			pz_red = pz_in + PI_Q30;
			pflip  = 1'b1;
		end
		if (rz_in > HALF_PI_Q30) begin
			rz_red = rz_in - PI_Q30;
			rflip  = 1'b1;
		end else if (rz_in < -HALF_PI_Q30) begin
			rz_red = rz_in + PI_Q30;
			rflip  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s[0] <= GAIN_Q30;
			py_s[0] <= '0;
			pz_s[0] <= pz_red;
			rx_s[0] <= GAIN_Q30;
			ry_s[0] <= '0;
			rz_s[0] <= rz_red;
			pf_s[0] <= pflip;
			rf_s[0] <= rflip;
			mx_s[0] <= mag_x;
			my_s[0] <= mag_y;
			mz_s[0] <= mag_z;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam ang_t ATAN_K = ang_t'(atan_q30(k));
		logic pdir, rdir;

		assign pdir = !pz_s[k][AW-1];
		assign rdir = !rz_s[k][AW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				px_s[k+1] <= pdir ? px_s[k] - (py_s[k] >>> k) : px_s[k] + (py_s[k] >>> k);
				py_s[k+1] <= pdir ? py_s[k] + (px_s[k] >>> k) : py_s[k] - (px_s[k] >>> k);
				pz_s[k+1] <= pdir ? pz_s[k] - ATAN_K : pz_s[k] + ATAN_K;
				rx_s[k+1] <= rdir ? rx_s[k] - (ry_s[k] >>> k) : rx_s[k] + (ry_s[k] >>> k);
				ry_s[k+1] <= rdir ? ry_s[k] + (rx_s[k] >>> k) : ry_s[k] - (rx_s[k] >>> k);
				rz_s[k+1] <= rdir ? rz_s[k] - ATAN_K : rz_s[k] + ATAN_K;
				pf_s[k+1] <= pf_s[k];
				rf_s[k+1] <= rf_s[k];
				mx_s[k+1] <= mx_s[k];
				my_s[k+1] <= my_s[k];
				mz_s[k+1] <= mz_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s <= 1'b0;
		end else if (en) begin
			fv_s <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tilt_s.cp <= trig_t'(pf_s[STEPS] ? -px_s[STEPS] : px_s[STEPS]);
			tilt_s.sp <= trig_t'(pf_s[STEPS] ? -py_s[STEPS] : py_s[STEPS]);
			tilt_s.cr <= trig_t'(rf_s[STEPS] ? -rx_s[STEPS] : rx_s[STEPS]);
			tilt_s.sr <= trig_t'(rf_s[STEPS] ? -ry_s[STEPS] : ry_s[STEPS]);
			tilt_s.mx <= mx_s[STEPS];
			tilt_s.my <= my_s[STEPS];
			tilt_s.mz <= mz_s[STEPS];
		end
	end

	assign out_valid = fv_s;
	assign tilt      = tilt_s;

endmodule

FILE: src/tch_atan.sv
// Pipelined vectoring CORDIC giving atan2 of the horizontal field, rounded to Q3.13.
`timescale 1ns / 1ps
module tch_atan (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  tch_pkg::fld_t xh,
	input  tch_pkg::fld_t yh,
	output logic          out_valid,
	output tch_pkg::smp_t heading
);
	import tch_pkg::*;

	logic v_s  [0:STEPS];
	fld_t ax_s [0:STEPS];
	fld_t ay_s [0:STEPS];
	ang_t az_s [0:STEPS];
	logic zr_s [0:STEPS];

	logic hv_s;
	smp_t heading_s;
	ang_t hz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// Left half plane: start from +-pi and mirror the vector.
	always_ff @(posedge clk) begin
		if (en) begin
			zr_s[0] <= (xh == '0) && (yh == '0);
			if (xh[HW-1]) begin
				ax_s[0] <= -xh;
				ay_s[0] <= -yh;
				az_s[0] <= yh[HW-1] ? -PI_Q30 : PI_Q30;
			end else begin
				ax_s[0] <= xh;
				ay_s[0] <= yh;
				az_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam ang_t ATAN_K = ang_t'(atan_q30(k));
		logic dir;

		assign dir = !ay_s[k][HW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ax_s[k+1] <= dir ? ax_s[k] + (ay_s[k] >>> k) : ax_s[k] - (ay_s[k] >>> k);
				ay_s[k+1] <= dir ? ay_s[k] - (ax_s[k] >>> k) : ay_s[k] + (ax_s[k] >>> k);
				az_s[k+1] <= dir ? az_s[k] + ATAN_K : az_s[k] - ATAN_K;
				zr_s[k+1] <= zr_s[k];
			end
		end
	end

	assign hz = (az_s[STEPS] + ROUND_Q30) >>> OUT_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_s <= 1'b0;
		end else if (en) begin
			hv_s <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (zr_s[STEPS]) begin
				heading_s <= '0;
			end else if (hz > ang_t'(HEAD_MAX)) begin
				heading_s <= smp_t'(HEAD_MAX);
			end else if (hz < ang_t'(-HEAD_MAX)) begin
				heading_s <= smp_t'(-HEAD_MAX);
			end else begin
				heading_s <= smp_t'(hz);
			end
		end
	end

	assign out_valid = hv_s;
	assign heading   = heading_s;

endmodule

FILE: src/tilt_compensated_heading.sv
// Top level: tilt-compensated compass heading from one magnetometer sample and attitude.
//
// Input channel: in_valid / in_stall with mag_x, mag_y, mag_z (signed counts) and
// pitch_angle, roll_angle (signed Q3.13 rad). Output channel: out_valid / out_stall
// with heading_angle, atan2(Yh, Xh) in signed Q3.13 rad, saturated to +-pi.
// A transfer happens at a rising edge where valid is high and stall is low.
// One result per sample, in order.
// Stages, in order: one reduction stage, one stage per step of the sin/cos CORDIC,
// a sign-fix stage, three multiply/add stages, a quadrant stage, one stage per
// step of the atan2 CORDIC and a rounding stage that is the output register.
// Throughput: one sample per cycle unless frozen; all stages advance together.
// When out_stall holds back a waiting result, the pipeline freezes and in_stall
// rises in the same cycle; nothing is dropped or repeated.
// Reset (arst_n low) clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps
module tilt_compensated_heading (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tch_pkg::smp_t mag_x,
	input  tch_pkg::smp_t mag_y,
	input  tch_pkg::smp_t mag_z,
	input  tch_pkg::smp_t pitch_angle,
	input  tch_pkg::smp_t roll_angle,
	output logic          out_valid,
	input  logic          out_stall,
	output tch_pkg::smp_t heading_angle
);
	import tch_pkg::*;

	localparam int TRIG_BOUND = (1 << 30) + (1 << 20);

	logic  en;
	logic  tilt_v;
	tilt_t tilt;

	logic  v_s1, v_s2, v_s3;
	trig_t ss_s1, sc_s1, cp_s1, sp_s1, cr_s1;
	smp_t  mx_s1, my_s1, mz_s1;
	prd_t  t1_s2, t2_s2, t3_s2, t4_s2, t5_s2;
	fld_t  xh_s3, yh_s3;

	logic signed [2*TW-1:0] ss_full, sc_full;

	// Advance whenever the output slot is free or being taken.
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	tch_tilt u_tilt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.mag_x      (mag_x),
		.mag_y      (mag_y),
		.mag_z      (mag_z),
		.pitch_angle(pitch_angle),
		.roll_angle (roll_angle),
		.out_valid  (tilt_v),
		.tilt       (tilt)
	);

	assign ss_full = (2*TW)'(tilt.sr) * (2*TW)'(tilt.sp);
	assign sc_full = (2*TW)'(tilt.sr) * (2*TW)'(tilt.cp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= tilt_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s1 <= trig_t'(ss_full >>> ONE_SHIFT);
			sc_s1 <= trig_t'(sc_full >>> ONE_SHIFT);
			cp_s1 <= tilt.cp;
			sp_s1 <= tilt.sp;
			cr_s1 <= tilt.cr;
			mx_s1 <= tilt.mx;
			my_s1 <= tilt.my;
			mz_s1 <= tilt.mz;

			t1_s2 <= prd_t'(mx_s1) * prd_t'(cp_s1);
			t2_s2 <= prd_t'(mz_s1) * prd_t'(sp_s1);
			t3_s2 <= prd_t'(mx_s1) * prd_t'(ss_s1);
			t4_s2 <= prd_t'(my_s1) * prd_t'(cr_s1);
			t5_s2 <= prd_t'(mz_s1) * prd_t'(sc_s1);

			xh_s3 <= fld_t'(t1_s2) + fld_t'(t2_s2);
			yh_s3 <= fld_t'(t3_s2) + fld_t'(t4_s2) - fld_t'(t5_s2);
		end
	end

	tch_atan u_atan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.xh       (xh_s3),
		.yh       (yh_s3),
		.out_valid(out_valid),
		.heading  (heading_angle)
	);

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading_angle <= smp_t'(HEAD_MAX)) && (heading_angle >= smp_t'(-HEAD_MAX)))
		else $error("heading outside +-pi");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(xh_s3) && $stable(yh_s3) && $stable(v_s3)))
		else $error("pipeline moved during output stall");

	a_trig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tilt_v |-> (tilt.cp <= TRIG_BOUND) && (tilt.cp >= -TRIG_BOUND)
			&& (tilt.sr <= TRIG_BOUND) && (tilt.sr >= -TRIG_BOUND))
		else $error("sin/cos out of unit range");

endmodule

FILE: bench/tilt_compensated_heading_test.sv
// Self-checking bench for the tilt-compensated heading pipeline: random and corner samples.
`timescale 1ns / 1ps

class heading_scoreboard;
	localparam longint GAIN = 64'sd652032874;
	localparam longint PI_Q = 64'sd3373259426;
	localparam longint HALF_PI_Q = 64'sd1686629713;
	localparam longint HMAX = 64'sd25736;

	logic signed [15:0] pending_headings[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// floor division by 2^s; >>> on longint is arithmetic
	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_entry(int i);
		return longint'(tch_pkg::atan_q30(i));
	endfunction

	function automatic void trig_of(logic signed [15:0] a, output longint c, output longint s);
		longint z, x, y, nx;
		bit flip;
		z = longint'(a) * 131072;
		x = GAIN;
		y = 0;
		flip = 0;
		if (z > HALF_PI_Q) begin
			z -= PI_Q;
			flip = 1;
		end else if (z < -HALF_PI_Q) begin
			z += PI_Q;
			flip = 1;
		end
		for (int i = 0; i < tch_pkg::STEPS; i++) begin
			if (z >= 0) begin
				nx = x - fshr(y, i);
				y = y + fshr(x, i);
				z -= atan_entry(i);
			end else begin
				nx = x + fshr(y, i);
				y = y - fshr(x, i);
				z += atan_entry(i);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, nx;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Q : -PI_Q;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < tch_pkg::STEPS; i++) begin
			if (y >= 0) begin
				nx = x + fshr(y, i);
				y = y - fshr(x, i);
				z += atan_entry(i);
			end else begin
				nx = x - fshr(y, i);
				y = y + fshr(x, i);
				z -= atan_entry(i);
			end
			x = nx;
		end
		return z;
	endfunction

	function void note_sample(logic signed [15:0] mx, logic signed [15:0] my,
			logic signed [15:0] mz, logic signed [15:0] pitch, logic signed [15:0] roll);
		longint cp, sp, cr, sr, xh, yh, h;
		trig_of(pitch, cp, sp);
		trig_of(roll, cr, sr);
		xh = longint'(mx) * cp + longint'(mz) * sp;
		yh = longint'(mx) * fshr(sr * sp, 30) + longint'(my) * cr
			- longint'(mz) * fshr(sr * cp, 30);
		if (xh == 0 && yh == 0)
			h = 0;
		else begin
			h = fshr(vector_angle(yh, xh) + 65536, 17);
			if (h > HMAX) h = HMAX;
			if (h < -HMAX) h = -HMAX;
		end
		pending_headings.push_back(h[15:0]);
	endfunction

	function void check_heading(logic signed [15:0] got);
		logic signed [15:0] want;
		if (pending_headings.size() == 0) begin
			$error("heading_angle: unexpected transfer, actual %0d", got);
			errors++;
			return;
		end
		want = pending_headings.pop_front();
		if (got !== want) begin
			$error("heading_angle: expected %0d, actual %0d", want, got);
			errors++;
		end
	endfunction
endclass

module tilt_compensated_heading_test;
	import tch_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	smp_t mag_x = '0, mag_y = '0, mag_z = '0, pitch_angle = '0, roll_angle = '0;
	logic out_valid;
	logic out_stall = 0;
	smp_t heading_angle;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	heading_scoreboard board = new();

	tilt_compensated_heading u_top (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// outputs sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_heading(heading_angle);
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// in_valid stays high after a transfer; the next sample, an idle cycle or drain sets it
	task automatic send_sample(smp_t x, smp_t y, smp_t z, smp_t p, smp_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		mag_x <= x;
		mag_y <= y;
		mag_z <= z;
		pitch_angle <= p;
		roll_angle <= r;
		do @(posedge clk); while (in_stall);
		board.note_sample(x, y, z, p, r);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending_headings.size() != 0) @(negedge clk);
	endtask

	function automatic smp_t any_angle();
		case ($urandom_range(3))
			0: return smp_t'($urandom);
			1: return smp_t'($signed($urandom_range(25736 * 2)) - 25736);
			2: return smp_t'($signed($urandom_range(12868 * 2)) - 12868);
			default: return smp_t'($signed($urandom_range(1200)) - 600);
		endcase
	endfunction

	task automatic random_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n)
			send_sample(smp_t'($urandom), smp_t'($urandom), smp_t'($urandom),
				any_angle(), any_angle());
		// hold until every expected heading is back
		drain();
	endtask

	initial begin
		#200000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// extremes, zero field, negative Xh with zero Yh, angles past pi/2 and past pi
		send_sample(0, 0, 0, 0, 0);
		send_sample(-100, 0, 0, 0, 0);
		send_sample(100, 0, 0, 0, 0);
		send_sample(0, 100, 0, 0, 0);
		send_sample(0, -100, 0, 0, 0);
		send_sample(32767, 32767, 32767, 32767, 32767);
		send_sample(-32768, -32768, -32768, -32768, -32768);
		send_sample(32767, -32768, 32767, 25736, -25736);
		send_sample(-32768, 32767, -32768, -25736, 25736);
		send_sample(1000, 2000, -3000, 12868, -12868);
		send_sample(1000, 2000, -3000, 12869, -12869);
		send_sample(-500, 700, 900, 20000, -20000);
		send_sample(-500, 700, 900, 30000, -30000);
		send_sample(-32768, 0, 0, 0, 0);
		send_sample(0, 0, 32767, 12868, 0);
		send_sample(-1, -1, -1, -1, -1);
		send_sample(16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA, 16'h5555);
		send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA);
		drain();
		random_phase(300, 0, 0);
		random_phase(250, 75, 0);
		random_phase(250, 0, 75);
		random_phase(300, 23, 23);
		recv_stall_pct = 0;
		repeat (2 * STEPS + 20) @(negedge clk);
		if (board.errors == 0 && board.pending_headings.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
